// ----- rtl/limit_order_book_matcher_defines.svh -----
// Assertion macros for the limit order book matcher.
// Depends on nothing; files that assert take it by include.
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
// Implication in the same cycle, reset disables the check.
`define LOBM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lobm assertion failed");
// Implication checked in the next cycle, reset disables the check.
`define LOBM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lobm assertion failed");
`endif

// ----- rtl/lobm_pkg.sv -----
// Shared constants, codes and types of the limit order book matcher.
// Depends on nothing.
package lobm_pkg;
    localparam int NUM_INSTRUMENTS = 4;
    localparam int BOOK_DEPTH = 64;
    localparam int MAX_FILLS = 63;
    localparam int TOTAL_SLOTS = NUM_INSTRUMENTS * 2 * BOOK_DEPTH;
    localparam int SLOT_W = $clog2(TOTAL_SLOTS);
    localparam int CNT_W = $clog2(TOTAL_SLOTS + 1);
    localparam int FILL_W = 6;
    localparam int PRICE_W = 32;
    localparam int QTY_W = 32;
    localparam int ID_W = 24;
    localparam int INS_W = 2;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;
    localparam logic SIDE_BUY = 1'b0;

    localparam logic [1:0] KIND_OPEN = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [1:0] ST_OPEN = 2'd0;
    localparam logic [1:0] ST_PARTIAL = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    id;
    } slot_t;

    typedef struct packed {
        logic               want_low;
        logic               have_best;
        logic [PRICE_W-1:0] best_price;
        logic [ID_W-1:0]    best_id;
    } cmp_ctl_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ID_W-1:0]    inc_id;
        logic [1:0]         inc_st;
        logic [ID_W-1:0]    rest_id;
        logic [1:0]         rest_st;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE,
        S_BEST,
        S_PRICE,
        S_FILL,
        S_CANCEL,
        S_FLUSH
    } state_t;
endpackage

// ----- rtl/lobm_slot_ram.sv -----
// Slot memory of all order book sides, one write and one registered read port.
// Depends on lobm_pkg.
module lobm_slot_ram
(
    input  logic                      clk,
    input  logic                      we,
    input  logic [lobm_pkg::SLOT_W-1:0] waddr,
    input  lobm_pkg::slot_t           wdata,
    input  logic [lobm_pkg::SLOT_W-1:0] raddr,
    output lobm_pkg::slot_t           rdata
);
    lobm_pkg::slot_t mem [lobm_pkg::TOTAL_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/lobm_best_cmp.sv -----
// Shared compare unit: decides whether a slot beats the best one so far.
// Depends on lobm_pkg.
module lobm_best_cmp
(
    input  lobm_pkg::cmp_ctl_t ctl,
    input  lobm_pkg::slot_t    cand,
    output logic               better
);
    always_comb
    begin
        if (!cand.valid)
        begin
            better = 1'b0;
        end
        else if (!ctl.have_best)
        begin
            better = 1'b1;
        end
        else if (cand.price == ctl.best_price)
        begin
            better = cand.id < ctl.best_id;
        end
        else if (ctl.want_low)
        begin
            better = cand.price < ctl.best_price;
        end
        else
        begin
            better = cand.price > ctl.best_price;
        end
    end
endmodule

// ----- rtl/limit_order_book_matcher.sv -----
// Limit order book matcher: sequencer, result register and book state.
// Depends on lobm_pkg, lobm_slot_ram, lobm_best_cmp and the defines header.
//
// Usage: commands enter on the in_valid/in_ready channel, one transaction
// per command. A place command yields an open confirm or a reject, then one
// fill result per match; the final result of a command carries last. A
// cancel command yields no result. Results leave on out_valid/out_ready.
// Timing: every scan walks slots through the read port of the slot memory,
// one slot a cycle; the best-match scan runs them through the compare unit.
// A place first scans its own side for a free slot, then scans the opposite
// side for the best match, again after each fill, then sends the final result.
// A cancel scans all TOTAL_SLOTS slots.
// After reset the block clears all TOTAL_SLOTS slots (512) of the slot memory
// and keeps in_ready low meanwhile. When the receiver stalls, the sequencer
// waits at its next result until the output register is free, and the
// next command may be taken while the final result still waits.
`include "limit_order_book_matcher_defines.svh"
module limit_order_book_matcher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [1:0]  instrument,
    input  logic        side,
    input  logic [31:0] limit_price,
    input  logic [31:0] quantity,
    input  logic [23:0] cancel_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [23:0] incoming_id,
    output logic [1:0]  incoming_status,
    output logic [23:0] resting_id,
    output logic [1:0]  resting_status,
    output logic [31:0] trade_price,
    output logic [31:0] trade_quantity,
    output logic        last
);
    localparam int SW = lobm_pkg::SLOT_W;
    localparam int CW = lobm_pkg::CNT_W;

    lobm_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] len_reg, len_next;
    logic [SW-1:0] base_reg, base_next;
    logic rvld_reg, rvld_next;
    logic [SW-1:0] raddr_reg, raddr_next;
    logic [lobm_pkg::ID_W-1:0] next_id_reg, next_id_next;
    logic [lobm_pkg::PRICE_W-1:0] ltp_reg [lobm_pkg::NUM_INSTRUMENTS];
    logic [lobm_pkg::PRICE_W-1:0] ltp_next [lobm_pkg::NUM_INSTRUMENTS];
    logic [lobm_pkg::FILL_W-1:0] fills_reg, fills_next;
    logic found_reg, found_next;
    logic [SW-1:0] free_reg, free_next;
    logic have_reg, have_next;
    lobm_pkg::slot_t best_reg, best_next;
    logic [SW-1:0] best_slot_reg, best_slot_next;
    logic [lobm_pkg::PRICE_W-1:0] tp_reg, tp_next;
    logic [lobm_pkg::QTY_W-1:0] tq_reg, tq_next;
    logic [lobm_pkg::INS_W-1:0] ins_reg, ins_next;
    logic side_reg, side_next;
    logic [lobm_pkg::PRICE_W-1:0] price_reg, price_next;
    logic [lobm_pkg::QTY_W-1:0] qty_reg, qty_next;
    logic [lobm_pkg::ID_W-1:0] cid_reg, cid_next;
    logic [lobm_pkg::ID_W-1:0] id_reg, id_next;
    lobm_pkg::res_t pend_reg, pend_next;
    lobm_pkg::res_t out_reg, out_next;
    logic out_last_reg, out_last_next;
    logic out_valid_reg, out_valid_next;

    logic mem_we;
    logic [SW-1:0] mem_waddr;
    lobm_pkg::slot_t mem_wdata;
    logic [SW-1:0] mem_raddr;
    lobm_pkg::slot_t mem_rdata;
    lobm_pkg::cmp_ctl_t cmp_ctl;
    logic cmp_better;

    logic out_free;
    logic issuing;
    logic scan_done;
    logic [lobm_pkg::PRICE_W-1:0] bid;
    logic [lobm_pkg::PRICE_W-1:0] ask;
    logic [lobm_pkg::PRICE_W-1:0] prev_tp;
    logic [lobm_pkg::QTY_W-1:0] inc_left;
    logic [lobm_pkg::QTY_W-1:0] rest_left;
    logic [lobm_pkg::FILL_W:0] fills_inc;

    lobm_slot_ram u_ram
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lobm_best_cmp u_cmp
    (
        .ctl    (cmp_ctl),
        .cand   (mem_rdata),
        .better (cmp_better)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign issuing = cnt_reg < len_reg;
    assign scan_done = !issuing && !rvld_reg;
    assign mem_raddr = base_reg + SW'(cnt_reg);
    assign bid = (side_reg == lobm_pkg::SIDE_BUY) ? price_reg : best_reg.price;
    assign ask = (side_reg == lobm_pkg::SIDE_BUY) ? best_reg.price : price_reg;
    assign prev_tp = ltp_reg[ins_reg];
    assign inc_left = qty_reg - tq_reg;
    assign rest_left = best_reg.qty - tq_reg;
    assign fills_inc = (lobm_pkg::FILL_W + 1)'(fills_reg) + 1'b1;

    assign cmp_ctl.want_low = side_reg == lobm_pkg::SIDE_BUY;
    assign cmp_ctl.have_best = have_reg;
    assign cmp_ctl.best_price = best_reg.price;
    assign cmp_ctl.best_id = best_reg.id;

    assign in_ready = state_reg == lobm_pkg::S_IDLE;
    assign out_valid = out_valid_reg;
    assign kind = out_reg.kind;
    assign incoming_id = out_reg.inc_id;
    assign incoming_status = out_reg.inc_st;
    assign resting_id = out_reg.rest_id;
    assign resting_status = out_reg.rest_st;
    assign trade_price = out_reg.price;
    assign trade_quantity = out_reg.qty;
    assign last = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lobm_pkg::S_CLEAR;
            cnt_reg <= '0;
            len_reg <= '0;
            rvld_reg <= 1'b0;
            next_id_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < lobm_pkg::NUM_INSTRUMENTS; i++)
            begin
                ltp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            len_reg <= len_next;
            rvld_reg <= rvld_next;
            next_id_reg <= next_id_next;
            out_valid_reg <= out_valid_next;
            ltp_reg <= ltp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        raddr_reg <= raddr_next;
        fills_reg <= fills_next;
        found_reg <= found_next;
        free_reg <= free_next;
        have_reg <= have_next;
        best_reg <= best_next;
        best_slot_reg <= best_slot_next;
        tp_reg <= tp_next;
        tq_reg <= tq_next;
        ins_reg <= ins_next;
        side_reg <= side_next;
        price_reg <= price_next;
        qty_reg <= qty_next;
        cid_reg <= cid_next;
        id_reg <= id_next;
        pend_reg <= pend_next;
        out_reg <= out_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        len_next = len_reg;
        base_next = base_reg;
        rvld_next = 1'b0;
        raddr_next = mem_raddr;
        next_id_next = next_id_reg;
        ltp_next = ltp_reg;
        fills_next = fills_reg;
        found_next = found_reg;
        free_next = free_reg;
        have_next = have_reg;
        best_next = best_reg;
        best_slot_next = best_slot_reg;
        tp_next = tp_reg;
        tq_next = tq_reg;
        ins_next = ins_reg;
        side_next = side_reg;
        price_next = price_reg;
        qty_next = qty_reg;
        cid_next = cid_reg;
        id_next = id_reg;
        pend_next = pend_reg;
        out_next = out_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we = 1'b0;
        mem_waddr = raddr_reg;
        mem_wdata = mem_rdata;

        case (state_reg)
            lobm_pkg::S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_waddr = SW'(cnt_reg);
                mem_wdata = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(lobm_pkg::TOTAL_SLOTS - 1))
                begin
                    cnt_next = '0;
                    state_next = lobm_pkg::S_IDLE;
                end
            end
            lobm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ins_next = instrument;
                    side_next = side;
                    price_next = limit_price;
                    qty_next = quantity;
                    cid_next = cancel_id;
                    cnt_next = '0;
                    found_next = 1'b0;
                    if (command == lobm_pkg::CMD_CANCEL)
                    begin
                        base_next = '0;
                        len_next = CW'(lobm_pkg::TOTAL_SLOTS);
                        state_next = lobm_pkg::S_CANCEL;
                    end
                    else
                    begin
                        id_next = next_id_reg;
                        next_id_next = next_id_reg + 1'b1;
                        base_next = SW'(int'({instrument, side}) * lobm_pkg::BOOK_DEPTH);
                        len_next = CW'(lobm_pkg::BOOK_DEPTH);
                        if (int'(instrument) < lobm_pkg::NUM_INSTRUMENTS)
                        begin
                            state_next = lobm_pkg::S_FREE;
                        end
                        else
                        begin
                            pend_next = '0;
                            pend_next.kind = lobm_pkg::KIND_REJECT;
                            pend_next.inc_id = next_id_reg;
                            qty_next = '0;
                            state_next = lobm_pkg::S_FLUSH;
                        end
                    end
                end
            end
            lobm_pkg::S_FREE:
            begin
                if (issuing)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rvld_next = 1'b1;
                end
                if (rvld_reg && !mem_rdata.valid && !found_reg)
                begin
                    found_next = 1'b1;
                    free_next = raddr_reg;
                end
                if (scan_done)
                begin
                    pend_next = '0;
                    pend_next.inc_id = id_reg;
                    if (!found_reg)
                    begin
                        pend_next.kind = lobm_pkg::KIND_REJECT;
                        qty_next = '0;
                        state_next = lobm_pkg::S_FLUSH;
                    end
                    else
                    begin
                        pend_next.kind = lobm_pkg::KIND_OPEN;
                        cnt_next = '0;
                        have_next = 1'b0;
                        fills_next = '0;
                        base_next = SW'(int'({ins_reg, !side_reg}) * lobm_pkg::BOOK_DEPTH);
                        if (qty_reg == '0)
                        begin
                            state_next = lobm_pkg::S_FLUSH;
                        end
                        else
                        begin
                            state_next = lobm_pkg::S_BEST;
                        end
                    end
                end
            end
            lobm_pkg::S_BEST:
            begin
                if (issuing)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rvld_next = 1'b1;
                end
                if (rvld_reg && cmp_better)
                begin
                    have_next = 1'b1;
                    best_next = mem_rdata;
                    best_slot_next = raddr_reg;
                end
                if (scan_done)
                begin
                    state_next = lobm_pkg::S_PRICE;
                end
            end
            lobm_pkg::S_PRICE:
            begin
                if (!have_reg || bid < ask)
                begin
                    state_next = lobm_pkg::S_FLUSH;
                end
                else
                begin
                    if (bid == ask || prev_tp > bid)
                    begin
                        tp_next = bid;
                    end
                    else if (prev_tp < ask)
                    begin
                        tp_next = ask;
                    end
                    else
                    begin
                        tp_next = prev_tp;
                    end
                    tq_next = (qty_reg < best_reg.qty) ? qty_reg : best_reg.qty;
                    state_next = lobm_pkg::S_FILL;
                end
            end
            lobm_pkg::S_FILL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = pend_reg;
                    out_last_next = 1'b0;
                    pend_next.kind = lobm_pkg::KIND_FILL;
                    pend_next.inc_id = id_reg;
                    pend_next.inc_st = (inc_left == '0) ? lobm_pkg::ST_DONE
                                                         : lobm_pkg::ST_PARTIAL;
                    pend_next.rest_id = best_reg.id;
                    pend_next.rest_st = (rest_left == '0) ? lobm_pkg::ST_DONE
                                                           : lobm_pkg::ST_PARTIAL;
                    pend_next.price = tp_reg;
                    pend_next.qty = tq_reg;
                    mem_we = 1'b1;
                    mem_waddr = best_slot_reg;
                    mem_wdata = best_reg;
                    mem_wdata.qty = rest_left;
                    mem_wdata.valid = rest_left != '0;
                    ltp_next[ins_reg] = tp_reg;
                    qty_next = inc_left;
                    fills_next = fills_reg + 1'b1;
                    cnt_next = '0;
                    have_next = 1'b0;
                    if (int'(fills_inc) < lobm_pkg::MAX_FILLS && inc_left != '0)
                    begin
                        state_next = lobm_pkg::S_BEST;
                    end
                    else
                    begin
                        state_next = lobm_pkg::S_FLUSH;
                    end
                end
            end
            lobm_pkg::S_CANCEL:
            begin
                if (issuing)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    rvld_next = 1'b1;
                end
                if (rvld_reg && mem_rdata.valid && mem_rdata.id == cid_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = raddr_reg;
                    mem_wdata = mem_rdata;
                    mem_wdata.valid = 1'b0;
                end
                if (scan_done)
                begin
                    state_next = lobm_pkg::S_IDLE;
                end
            end
            lobm_pkg::S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = pend_reg;
                    out_last_next = 1'b1;
                    if (qty_reg != '0)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = free_reg;
                        mem_wdata.valid = 1'b1;
                        mem_wdata.price = price_reg;
                        mem_wdata.qty = qty_reg;
                        mem_wdata.id = id_reg;
                    end
                    state_next = lobm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lobm_pkg::S_IDLE;
            end
        endcase
    end

    `LOBM_ASSERT_NEXT(a_id_advance,
        in_valid && in_ready && command == lobm_pkg::CMD_PLACE,
        next_id_reg == lobm_pkg::ID_W'($past(next_id_reg) + 1'b1))
    `LOBM_ASSERT_NEXT(a_fill_pending,
        state_reg == lobm_pkg::S_FILL && out_free,
        pend_reg.kind == lobm_pkg::KIND_FILL && out_valid_reg)
    `LOBM_ASSERT_NOW(a_fill_bound,
        state_reg == lobm_pkg::S_BEST,
        int'(fills_reg) < lobm_pkg::MAX_FILLS)
endmodule
